FILE: design/pid_fan_speed_controller_unit_defines.svh
// Assertion macros for the PID fan speed controller RTL
`ifndef PID_FAN_SPEED_CONTROLLER_UNIT_DEFINES_SVH
`define PID_FAN_SPEED_CONTROLLER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define PFSC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pfsc: assertion failed");
// condition must never be seen outside reset
`define PFSC_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("pfsc: forbidden condition seen");
`else
`define PFSC_ASSERT(label, prop)
`define PFSC_ASSERT_NEVER(label, expr)
`endif
`endif

FILE: design/pfsc_pkg.sv
// Shared constants and types of the PID fan speed controller
package pfsc_pkg;

    localparam int TEMP_W    = 16;
    localparam int TARGET_W  = 7;
    localparam int SPEED_W   = 8;
    localparam int GAIN_W    = 16;
    localparam int IVL_W     = 8;
    localparam int PCT_OUT_W = 15;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    // full scale of the drive in percent
    localparam int PCT_FULL  = 100;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [GAIN_W-1:0]    gain_t;
    typedef logic [SPEED_W-1:0]   speed_t;

    // register indexes
    localparam cfg_idx_t CFG_TARGET   = 3'd0;
    localparam cfg_idx_t CFG_MIN_SPD  = 3'd1;
    localparam cfg_idx_t CFG_MAX_SPD  = 3'd2;
    localparam cfg_idx_t CFG_KP       = 3'd3;
    localparam cfg_idx_t CFG_KI       = 3'd4;
    localparam cfg_idx_t CFG_KD       = 3'd5;
    localparam cfg_idx_t CFG_INTERVAL = 3'd6;

    // register reset values
    localparam logic [TARGET_W-1:0] RST_TARGET   = 7'd55;
    localparam speed_t              RST_MIN_SPD  = 8'd35;
    localparam speed_t              RST_MAX_SPD  = 8'd255;
    localparam gain_t               RST_KP       = 16'd1280;
    localparam gain_t               RST_KI       = 16'd256;
    localparam gain_t               RST_KD       = 16'd3;
    localparam logic [IVL_W-1:0]    RST_INTERVAL = 8'd30;

endpackage

FILE: design/pfsc_mac.sv
// Bit-serial three-term gain multiply-accumulate (Kp*e + Ki*i + Kd*d)
module pfsc_mac #(
    parameter int ERR_W   = 17,
    parameter int INTEG_W = 15,
    localparam int SUM_W  = ERR_W + pfsc_pkg::GAIN_W + 2
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [ERR_W-1:0]   err,
    input  logic [INTEG_W-1:0]        integ,
    input  logic signed [ERR_W:0]     deriv,
    input  pfsc_pkg::gain_t           kp,
    input  pfsc_pkg::gain_t           ki,
    input  pfsc_pkg::gain_t           kd,
    output logic signed [SUM_W-1:0]   sum,
    output logic                      done
);

    localparam int CNT_W = $clog2(pfsc_pkg::GAIN_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(pfsc_pkg::GAIN_W - 1);

    logic                    busy_reg;
    logic                    done_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic [INTEG_W-1:0]      integ_reg;
    logic signed [ERR_W:0]   deriv_reg;
    pfsc_pkg::gain_t         kp_reg;
    pfsc_pkg::gain_t         ki_reg;
    pfsc_pkg::gain_t         kd_reg;
    logic signed [SUM_W-1:0] acc_reg;
    logic signed [SUM_W-1:0] acc_next;
    logic signed [SUM_W-1:0] term_p;
    logic signed [SUM_W-1:0] term_i;
    logic signed [SUM_W-1:0] term_d;

    // MSB-first: shift the sum, add the operands selected by the gain bits
    always_comb
    begin
        term_p   = kp_reg[pfsc_pkg::GAIN_W-1] ? SUM_W'(err_reg) : '0;
        term_i   = ki_reg[pfsc_pkg::GAIN_W-1] ? $signed(SUM_W'(integ_reg)) : '0;
        term_d   = kd_reg[pfsc_pkg::GAIN_W-1] ? SUM_W'(deriv_reg) : '0;
        acc_next = (acc_reg <<< 1) + term_p + term_i + term_d;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            err_reg   <= err;
            integ_reg <= integ;
            deriv_reg <= deriv;
            kp_reg    <= kp;
            ki_reg    <= ki;
            kd_reg    <= kd;
            acc_reg   <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            kp_reg  <= kp_reg << 1;
            ki_reg  <= ki_reg << 1;
            kd_reg  <= kd_reg << 1;
        end
    end

    assign sum  = acc_reg;
    assign done = done_reg;

endmodule

FILE: design/pfsc_spd.sv
// Percent to PWM mapping: bit-serial scale, rounding, serial divide by 100
module pfsc_spd #(
    parameter int FRAC_BITS = 8,
    localparam int PCT_W    = FRAC_BITS + 7
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PCT_W-1:0]  pct,
    input  pfsc_pkg::speed_t  pwm_floor,
    input  pfsc_pkg::speed_t  pwm_ceil,
    output pfsc_pkg::speed_t  speed,
    output logic              done
);

    localparam int SW    = pfsc_pkg::SPEED_W;
    localparam int ACC_W = PCT_W + SW;
    localparam int REM_W = $clog2((2 ** SW) * pfsc_pkg::PCT_FULL);
    localparam int CNT_W = $clog2(SW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SW - 1);
    localparam logic [PCT_W-1:0] FULL     = PCT_W'(pfsc_pkg::PCT_FULL << FRAC_BITS);
    localparam logic [ACC_W-1:0] HALF     = ACC_W'((pfsc_pkg::PCT_FULL / 2) << FRAC_BITS);
    localparam logic [REM_W-1:0] DVS_INIT = REM_W'(pfsc_pkg::PCT_FULL << (SW - 1));

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_RND  = 2'd2;
    localparam logic [1:0] PH_DIV  = 2'd3;

    logic [1:0]       phase_reg;
    logic [1:0]       phase_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [PCT_W-1:0] pct_reg;
    logic [PCT_W-1:0] comp_reg;
    logic             zero_reg;
    pfsc_pkg::speed_t min_sh_reg;
    pfsc_pkg::speed_t max_sh_reg;
    pfsc_pkg::speed_t max_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic [ACC_W-1:0] acc_rnd;
    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] dvs_reg;
    pfsc_pkg::speed_t q_reg;
    logic             ge;

    // num = min*(D-pct) + max*pct, one bit of min/max per cycle
    always_comb
    begin
        acc_next = (acc_reg << 1)
                 + (min_sh_reg[SW-1] ? ACC_W'(comp_reg) : '0)
                 + (max_sh_reg[SW-1] ? ACC_W'(pct_reg) : '0);
        acc_rnd  = acc_reg + HALF;
        ge       = (rem_reg >= dvs_reg);
    end

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    phase_next = PH_MUL;
                end
            end
            PH_MUL:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    phase_next = PH_RND;
                end
            end
            PH_RND:
            begin
                phase_next = PH_DIV;
            end
            PH_DIV:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == PH_DIV) && (cnt_reg == CNT_LAST);
            if (phase_reg == PH_MUL || phase_reg == PH_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_IDLE && start)
        begin
            pct_reg    <= pct;
            comp_reg   <= FULL - pct;
            zero_reg   <= (pct == '0);
            min_sh_reg <= pwm_floor;
            max_sh_reg <= pwm_ceil;
            max_reg    <= pwm_ceil;
            acc_reg    <= '0;
        end
        else if (phase_reg == PH_MUL)
        begin
            acc_reg    <= acc_next;
            min_sh_reg <= min_sh_reg << 1;
            max_sh_reg <= max_sh_reg << 1;
        end
        else if (phase_reg == PH_RND)
        begin
            // (num + D/2) >> T, the rest of the divide is by 100
            rem_reg <= acc_rnd[FRAC_BITS +: REM_W];
            dvs_reg <= DVS_INIT;
            q_reg   <= '0;
        end
        else if (phase_reg == PH_DIV)
        begin
            rem_reg <= ge ? rem_reg - dvs_reg : rem_reg;
            q_reg   <= {q_reg[SW-2:0], ge};
            dvs_reg <= dvs_reg >> 1;
        end
    end

    always_comb
    begin
        if (zero_reg)
        begin
            speed = '0;
        end
        else
        begin
            speed = (q_reg > max_reg) ? max_reg : q_reg;
        end
    end

    assign done = done_reg;

endmodule

FILE: design/pid_fan_speed_controller_unit.sv
// Top level of the PID fan speed controller: config, update timing, control FSM
// Each temperature request bumps a saturating sample count. The first request after
// reset, and any request that brings the count to control_interval or beyond, runs one
// PID step and produces one result request (fan_speed, drive_percent); all other
// requests are absorbed without a stall and produce nothing. An updating request holds
// in_stall high until its result is handed on, through these steps: form integral and
// derivative, the bit-serial gain multiply-accumulate (16 gain bits, one per cycle,
// then its done cycle), round and clamp the percent, the speed unit (8 multiply bits,
// rounding, 8 quotient bits of the divide by 100, done) and the hand-off of the
// result into the output register. If that register still holds an untaken result,
// the hand-off waits and the stall lasts that much longer. A finished result waits in
// that register while the next request is already taken.
// The user must write registers through cfg_we/cfg_index/cfg_data only while the
// block is idle; the block itself does not enforce this.
`include "pid_fan_speed_controller_unit_defines.svh"

module pid_fan_speed_controller_unit #(
    parameter int TEMP_FRAC_BITS = 8,
    parameter int GAIN_FRAC_BITS = 8
)(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [pfsc_pkg::TEMP_W-1:0] temperature,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [pfsc_pkg::SPEED_W-1:0]       fan_speed,
    output logic [pfsc_pkg::PCT_OUT_W-1:0]     drive_percent,
    input  logic                               cfg_we,
    input  logic [pfsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pfsc_pkg::CFG_W-1:0]         cfg_data
);

    localparam int T       = TEMP_FRAC_BITS;
    localparam int G       = GAIN_FRAC_BITS;
    // error holds temperature minus (target << T)
    localparam int ERR_W   = ((T + 8 > pfsc_pkg::TEMP_W) ? T + 8 : pfsc_pkg::TEMP_W) + 1;
    localparam int DRV_W   = ERR_W + 1;
    localparam int INTEG_W = T + 7;
    localparam int PCT_W   = T + 7;
    localparam int SUM_W   = ERR_W + pfsc_pkg::GAIN_W + 2;

    localparam logic [INTEG_W-1:0]      FULL_T  = INTEG_W'(pfsc_pkg::PCT_FULL << T);
    localparam logic signed [SUM_W-1:0] FULL_TG =
        SUM_W'(longint'(pfsc_pkg::PCT_FULL) << (T + G));
    localparam logic signed [SUM_W-1:0] HALF_G  = SUM_W'(longint'(1) << (G - 1));

    // controller states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_MAC  = 3'd2;
    localparam logic [2:0] S_PCT  = 3'd3;
    localparam logic [2:0] S_SPD  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // configuration registers
    logic [pfsc_pkg::TARGET_W-1:0] target_reg;
    pfsc_pkg::speed_t              min_reg;
    pfsc_pkg::speed_t              max_reg;
    pfsc_pkg::gain_t               kp_reg;
    pfsc_pkg::gain_t               ki_reg;
    pfsc_pkg::gain_t               kd_reg;
    logic [pfsc_pkg::IVL_W-1:0]    ivl_reg;

    // controller state
    logic [INTEG_W-1:0]         integral_sum_reg;
    logic signed [ERR_W-1:0]    last_err_reg;
    logic [pfsc_pkg::IVL_W-1:0] cnt_reg;
    logic [pfsc_pkg::IVL_W-1:0] cnt_inc;
    logic                       has_run_reg;

    logic                    in_acc;
    logic                    fire;
    logic signed [ERR_W-1:0] err_next;
    logic signed [ERR_W-1:0] err_reg;
    logic signed [DRV_W-1:0] integ_raw;
    logic [INTEG_W-1:0]      integ_clamp;
    logic signed [DRV_W-1:0] deriv;

    logic                    mac_start;
    logic                    mac_done;
    logic signed [SUM_W-1:0] mac_sum;
    logic signed [SUM_W-1:0] sum_rnd;
    logic [PCT_W-1:0]        pct_calc;
    logic [PCT_W-1:0]        pct_reg;

    logic             spd_start;
    logic             spd_done;
    pfsc_pkg::speed_t spd_speed;

    logic             out_load;
    logic             out_valid_reg;
    logic             out_valid_next;
    pfsc_pkg::speed_t fan_speed_reg;
    logic [PCT_W-1:0] drive_reg;

    // ---------------------------------------------------------------------------------
    // Configuration write port
    // ---------------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= pfsc_pkg::RST_TARGET;
            min_reg    <= pfsc_pkg::RST_MIN_SPD;
            max_reg    <= pfsc_pkg::RST_MAX_SPD;
            kp_reg     <= pfsc_pkg::RST_KP;
            ki_reg     <= pfsc_pkg::RST_KI;
            kd_reg     <= pfsc_pkg::RST_KD;
            ivl_reg    <= pfsc_pkg::RST_INTERVAL;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pfsc_pkg::CFG_TARGET:   target_reg <= cfg_data[pfsc_pkg::TARGET_W-1:0];
                pfsc_pkg::CFG_MIN_SPD:  min_reg    <= cfg_data[pfsc_pkg::SPEED_W-1:0];
                pfsc_pkg::CFG_MAX_SPD:  max_reg    <= cfg_data[pfsc_pkg::SPEED_W-1:0];
                pfsc_pkg::CFG_KP:       kp_reg     <= cfg_data[pfsc_pkg::GAIN_W-1:0];
                pfsc_pkg::CFG_KI:       ki_reg     <= cfg_data[pfsc_pkg::GAIN_W-1:0];
                pfsc_pkg::CFG_KD:       kd_reg     <= cfg_data[pfsc_pkg::GAIN_W-1:0];
                pfsc_pkg::CFG_INTERVAL: ivl_reg    <= cfg_data[pfsc_pkg::IVL_W-1:0];
                default:                ;
            endcase
        end
    end

    // ---------------------------------------------------------------------------------
    // Update timing: count saturates at all ones; an interval of zero fires every time
    // ---------------------------------------------------------------------------------
    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign cnt_inc  = (cnt_reg == '1) ? cnt_reg : cnt_reg + 1'b1;
    assign fire     = !has_run_reg || (cnt_inc >= ivl_reg);

    // error is formed as the request is taken
    assign err_next = ERR_W'(temperature)
                    - $signed(ERR_W'({target_reg, {T{1'b0}}}));

    // ---------------------------------------------------------------------------------
    // Integral (clamped to 0..100) and derivative
    // ---------------------------------------------------------------------------------
    always_comb
    begin
        integ_raw = DRV_W'(err_reg) + $signed(DRV_W'(integral_sum_reg));
        if (integ_raw[DRV_W-1])
        begin
            integ_clamp = '0;
        end
        else if (integ_raw > $signed(DRV_W'(FULL_T)))
        begin
            integ_clamp = FULL_T;
        end
        else
        begin
            integ_clamp = integ_raw[INTEG_W-1:0];
        end
        deriv = DRV_W'(err_reg) - DRV_W'(last_err_reg);
    end

    // ---------------------------------------------------------------------------------
    // PID sum to percent: negative or zero stops, 100 percent and above clamps,
    // otherwise round half up from T+G to T fraction bits
    // ---------------------------------------------------------------------------------
    always_comb
    begin
        sum_rnd = mac_sum + HALF_G;
        if (mac_sum[SUM_W-1] || mac_sum == '0)
        begin
            pct_calc = '0;
        end
        else if (mac_sum >= FULL_TG)
        begin
            pct_calc = FULL_T;
        end
        else
        begin
            pct_calc = sum_rnd[G +: PCT_W];
        end
    end

    assign mac_start = (state_reg == S_PREP);
    assign spd_start = (state_reg == S_PCT);

    // ---------------------------------------------------------------------------------
    // Control FSM
    // ---------------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && fire)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                state_next = S_MAC;
            end
            S_MAC:
            begin
                if (mac_done)
                begin
                    state_next = S_PCT;
                end
            end
            S_PCT:
            begin
                state_next = S_SPD;
            end
            S_SPD:
            begin
                if (spd_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register frees as soon as the downstream side takes the result
    assign out_load       = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cnt_reg          <= '0;
            has_run_reg      <= 1'b0;
            integral_sum_reg <= '0;
            last_err_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (in_acc)
            begin
                if (fire)
                begin
                    cnt_reg     <= '0;
                    has_run_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_inc;
                end
            end
            if (state_reg == S_PREP)
            begin
                integral_sum_reg <= integ_clamp;
                last_err_reg     <= err_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            err_reg <= err_next;
        end
        if (state_reg == S_PCT)
        begin
            pct_reg <= pct_calc;
        end
        if (out_load)
        begin
            fan_speed_reg <= spd_speed;
            drive_reg     <= pct_reg;
        end
    end

    // ---------------------------------------------------------------------------------
    // Serial arithmetic units
    // ---------------------------------------------------------------------------------
    pfsc_mac #(
        .ERR_W   (ERR_W),
        .INTEG_W (INTEG_W)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mac_start),
        .err   (err_reg),
        .integ (integ_clamp),
        .deriv (deriv),
        .kp    (kp_reg),
        .ki    (ki_reg),
        .kd    (kd_reg),
        .sum   (mac_sum),
        .done  (mac_done)
    );

    pfsc_spd #(
        .FRAC_BITS (T)
    ) u_spd (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (spd_start),
        .pct       (pct_calc),
        .pwm_floor (min_reg),
        .pwm_ceil  (max_reg),
        .speed     (spd_speed),
        .done      (spd_done)
    );

    assign out_valid     = out_valid_reg;
    assign fan_speed     = fan_speed_reg;
    assign drive_percent = pfsc_pkg::PCT_OUT_W'(drive_reg);

    // ---------------------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------------------
    `PFSC_ASSERT(a_result_from_done, $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
    `PFSC_ASSERT(a_fire_clears_count, in_acc && fire |=> cnt_reg == '0 && has_run_reg)
    `PFSC_ASSERT(a_zero_drive_stops, out_valid_reg && drive_reg == '0 |-> fan_speed_reg == '0)
    `PFSC_ASSERT_NEVER(a_drive_over_full, out_valid_reg && drive_reg > FULL_T)

endmodule
